// ----- design/soc_pkg.sv -----
`timescale 1ns / 1ps

package soc_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned INDEX_W = 10;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

endpackage

// ----- design/soc_store.sv -----
`timescale 1ns / 1ps

module soc_store #(
  parameter int unsigned DEPTH = soc_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [soc_pkg::DATA_W-1:0]  wr_data_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [soc_pkg::DATA_W-1:0]  rd_data_o
);

  logic [soc_pkg::DATA_W-1:0] mem [DEPTH];
  logic [soc_pkg::DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/sorted_occurrence_counter.sv -----
`timescale 1ns / 1ps
// Append, clear and unused actions pass from IDLE through FINISH into the output register.
// A query on a non-empty store runs a lower-bound binary search, a CHECK of the found entry and,
// on a match, an upper-bound search, one probe per cycle through the single-read-port memory.
// One item is in work at a time; the next is taken once a result sits in the output register.
// Reset clears the state, the fill count and the output valid flag only; no store sweep.
module sorted_occurrence_counter #(
  parameter int unsigned DEPTH = soc_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [soc_pkg::ACTION_W-1:0]       action_i,
  input  logic signed [soc_pkg::DATA_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [soc_pkg::STATUS_W-1:0]       status_o,
  output logic [soc_pkg::COUNT_W-1:0]        count_o,
  output logic [soc_pkg::INDEX_W-1:0]        first_index_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned SW = PW + 1;
  localparam int unsigned CNT_EXT = (PW > soc_pkg::COUNT_W) ? PW : soc_pkg::COUNT_W;
  localparam int unsigned IDX_EXT = (AW > soc_pkg::INDEX_W) ? AW : soc_pkg::INDEX_W;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  typedef enum logic [2:0] {
    IDLE,
    LOW,
    CHECK,
    UP,
    FINISH
  } state_e;

  state_e state_q, state_d;
  logic [PW-1:0] fill_q, fill_d;
  logic [PW-1:0] lo_q, lo_d;
  logic [PW-1:0] hi_q, hi_d;
  logic [PW-1:0] mid_q, mid_d;
  logic [PW-1:0] first_q, first_d;
  logic signed [soc_pkg::DATA_W-1:0] key_q, key_d;
  soc_pkg::status_e res_status_q, res_status_d;
  logic [PW-1:0] res_count_q, res_count_d;
  logic [PW-1:0] res_first_q, res_first_d;
  logic out_valid_q, out_valid_d;
  soc_pkg::status_e out_status_q, out_status_d;
  logic [PW-1:0] out_count_q, out_count_d;
  logic [PW-1:0] out_first_q, out_first_d;

  logic wr_en;
  logic [PW-1:0] rd_pos;
  logic [soc_pkg::DATA_W-1:0] rd_data;
  logic go_right;
  logic [SW-1:0] sum_right;
  logic [SW-1:0] sum_left;
  logic [SW-1:0] sum_start;
  logic [PW-1:0] lo_n;
  logic [PW-1:0] hi_n;
  logic [PW-1:0] mid_n;
  logic [PW-1:0] first_inc;
  logic [CNT_EXT-1:0] count_ext;
  logic [IDX_EXT-1:0] index_ext;

  soc_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(fill_q[AW-1:0]),
    .wr_data_i(value_i),
    .rd_addr_i(rd_pos[AW-1:0]),
    .rd_data_o(rd_data)
  );

  assign in_stall_o = (state_q != IDLE);

  always_comb begin
    sum_right = SW'(mid_q) + SW'(hi_q) + SW'(1);
    sum_left = SW'(lo_q) + SW'(mid_q);
    first_inc = first_q + PW'(1);
    sum_start = SW'(first_inc) + SW'(fill_q);
    if (state_q == UP) begin
      go_right = ($signed(rd_data) <= key_q);
    end else begin
      go_right = ($signed(rd_data) < key_q);
    end
    if (go_right) begin
      lo_n = mid_q + PW'(1);
      hi_n = hi_q;
      mid_n = sum_right[PW:1];
    end else begin
      lo_n = lo_q;
      hi_n = mid_q;
      mid_n = sum_left[PW:1];
    end
  end

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    lo_d = lo_q;
    hi_d = hi_q;
    mid_d = mid_q;
    first_d = first_q;
    key_d = key_q;
    res_status_d = res_status_q;
    res_count_d = res_count_q;
    res_first_d = res_first_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_count_d = out_count_q;
    out_first_d = out_first_q;
    wr_en = 1'b0;
    rd_pos = mid_q;
    unique case (state_q)
      IDLE: begin
        rd_pos = fill_q >> 1;
        if (in_valid_i) begin
          key_d = value_i;
          res_status_d = soc_pkg::ST_OK;
          res_count_d = '0;
          res_first_d = '0;
          state_d = FINISH;
          unique case (soc_pkg::action_e'(action_i))
            soc_pkg::ACT_APPEND: begin
              if (fill_q < DEPTH_P) begin
                wr_en = 1'b1;
                fill_d = fill_q + PW'(1);
              end else begin
                res_status_d = soc_pkg::ST_FULL;
              end
            end
            soc_pkg::ACT_QUERY: begin
              lo_d = '0;
              hi_d = fill_q;
              mid_d = fill_q >> 1;
              if (fill_q == '0) begin
                res_status_d = soc_pkg::ST_NOT_FOUND;
              end else begin
                state_d = LOW;
              end
            end
            soc_pkg::ACT_CLEAR: begin
              fill_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      LOW: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d = mid_n;
          rd_pos = mid_n;
        end else if (lo_n < fill_q) begin
          first_d = lo_n;
          rd_pos = lo_n;
          state_d = CHECK;
        end else begin
          res_status_d = soc_pkg::ST_NOT_FOUND;
          state_d = FINISH;
        end
      end
      CHECK: begin
        if (rd_data == key_q) begin
          lo_d = first_inc;
          hi_d = fill_q;
          if (first_inc < fill_q) begin
            mid_d = sum_start[PW:1];
            rd_pos = sum_start[PW:1];
            state_d = UP;
          end else begin
            res_count_d = PW'(1);
            res_first_d = first_q;
            state_d = FINISH;
          end
        end else begin
          res_status_d = soc_pkg::ST_NOT_FOUND;
          state_d = FINISH;
        end
      end
      UP: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d = mid_n;
          rd_pos = mid_n;
        end else begin
          res_count_d = lo_n - first_q;
          res_first_d = first_q;
          state_d = FINISH;
        end
      end
      FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_status_d = res_status_q;
          out_count_d = res_count_q;
          out_first_d = res_first_q;
          state_d = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      fill_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    mid_q <= mid_d;
    first_q <= first_d;
    key_q <= key_d;
    res_status_q <= res_status_d;
    res_count_q <= res_count_d;
    res_first_q <= res_first_d;
    out_status_q <= out_status_d;
    out_count_q <= out_count_d;
    out_first_q <= out_first_d;
  end

  assign count_ext = CNT_EXT'(out_count_q);
  assign index_ext = IDX_EXT'(out_first_q[AW-1:0]);
  assign out_valid_o = out_valid_q;
  assign status_o = out_status_q;
  assign count_o = count_ext[soc_pkg::COUNT_W-1:0];
  assign first_index_o = index_ext[soc_pkg::INDEX_W-1:0];

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= DEPTH_P)
    else $error("Fill count exceeds the store depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == LOW || state_q == UP) |-> lo_q < hi_q)
    else $error("Search window is empty while a search is running.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i == soc_pkg::ACT_APPEND && fill_q < DEPTH_P
    |=> fill_q == $past(fill_q) + PW'(1))
    else $error("Append did not advance the fill count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == soc_pkg::ST_NOT_FOUND |-> count_o == '0 && first_index_o == '0)
    else $error("A miss carries a nonzero count or index.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CHECK |-> first_q < fill_q)
    else $error("Match check reads beyond the fill count.");
`endif

endmodule
